### hdl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds in the same cycle as the trigger
`define ASSERT_NOW(lbl, clk, rst, trig, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("assertion failed");

// condition holds in the cycle after the trigger
`define ASSERT_NEXT(lbl, clk, rst, trig, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("assertion failed");

`endif

### hdl/lpet_pkg.sv
// types and constants for the play led, monitor led and end pulse timer
`timescale 1ns / 1ps

package lpet_pkg;

   // transaction op codes
   localparam logic [1:0] OP_TICK      = 2'd0;
   localparam logic [1:0] OP_TRIGGER   = 2'd1;
   localparam logic [1:0] OP_SET_STATE = 2'd2;

   // register indexes
   localparam logic [1:0] REG_BRIGHTNESS   = 2'd0;
   localparam logic [1:0] REG_STEREO_LINK  = 2'd1;
   localparam logic [1:0] REG_MONITOR_MODE = 2'd2;
   localparam logic [1:0] REG_LED_INHIBIT  = 2'd3;

   // monitor led modes
   localparam logic [1:0] MON_OFF        = 2'd0;
   localparam logic [1:0] MON_LEFT_BLINK = 2'd1;
   localparam logic [1:0] MON_RIGHT_BLINK = 2'd2;
   localparam logic [1:0] MON_STEADY     = 2'd3;

   localparam logic [4:0]  BRIGHTNESS_RESET = 5'd16;
   localparam logic [12:0] BLINK_ON_LIMIT   = 13'h0400;
   localparam logic [15:0] LONG_PLAY_MS     = 16'd300;
   localparam logic [5:0]  LONG_PLAY_LOAD   = 6'd35;
   localparam logic [5:0]  PULSE_OFFSET     = 6'd8;
   localparam logic [5:0]  FLICKER_OFFSET   = 6'd1;

   // ms*9/100 as ms*(9*5243) >> 19 and ms*9/250 as ms*(9*4195) >> 20,
   // exact for every ms up to the long play limit
   localparam logic [15:0] PULSE_RECIP   = 16'd47187;
   localparam int          PULSE_SHIFT   = 19;
   localparam logic [15:0] FLICKER_RECIP = 16'd37755;
   localparam int          FLICKER_SHIFT = 20;

   typedef struct packed {
      logic [1:0]  op;
      logic        channel;
      logic [15:0] play_time_ms;
      logic        play_on;
      logic [12:0] system_time;
   } lpet_req_type;

   typedef struct packed {
      logic play_led_left;
      logic play_led_right;
      logic monitor_led;
      logic end_out_left;
      logic end_out_right;
   } lpet_rsp_type;

endpackage

### hdl/led_pwm_and_end_pulse_timer.sv
// top level: play led pwm, monitor led and end-of-play pulse timer
`timescale 1ns / 1ps

// channel   ports              direction  content
// req       req_valid/ready    in         op, channel, play time, play state, system time
// rsp       rsp_valid/ready    out        three led drives, two end pulse outputs
// csr       csr_psel..pready   in/out     brightness, stereo link, monitor mode, inhibit
//
// one transaction per cycle unless the result is stalled: the state update and the result are computed in
// the accept cycle and the result sits in a single output register
// a new request is taken whenever the output register is empty or being drained
// reset clears all counters, play state and led drives and empties the output register
// a stalled result holds req_ready low, nothing is dropped

module led_pwm_and_end_pulse_timer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  lpet_pkg::lpet_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output lpet_pkg::lpet_rsp_type rsp_data,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [3:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);
   import lpet_pkg::*;

   // configuration registers
   logic [4:0] brightness_ff;
   logic       stereo_link_ff;
   logic [1:0] monitor_mode_ff;
   logic       led_inhibit_ff;

   // block state
   logic [3:0] pwm_phase_ff, pwm_phase_in;
   logic [5:0] flicker_ff [2];
   logic [5:0] flicker_in [2];
   logic [5:0] pulse_ff [2];
   logic [5:0] pulse_in [2];
   logic       play_ff [2];
   logic       play_in [2];
   logic       end_pin_ff [2];
   logic       end_pin_in [2];
   logic [2:0] led_hold_ff, led_hold_in;

   // output register
   logic         rsp_valid_ff;
   lpet_rsp_type rsp_data_ff, rsp_data_in;

   logic       req_fire;
   logic       csr_write;
   logic [1:0] csr_index;
   logic       on_phase;
   logic       mon_lit;
   logic       lit [2];
   logic       long_play;
   logic [8:0] ms_short;
   logic [24:0] pulse_prod;
   logic [24:0] flicker_prod;
   logic [5:0] pulse_load;
   logic [5:0] flicker_load;

   // ------------------------------------------------------------ handshake
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ------------------------------------------------------------ csr port
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff   <= BRIGHTNESS_RESET;
         stereo_link_ff  <= 1'b0;
         monitor_mode_ff <= MON_OFF;
         led_inhibit_ff  <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            REG_BRIGHTNESS:   brightness_ff   <= csr_pwdata[4:0];
            REG_STEREO_LINK:  stereo_link_ff  <= csr_pwdata[0];
            REG_MONITOR_MODE: monitor_mode_ff <= csr_pwdata[1:0];
            REG_LED_INHIBIT:  led_inhibit_ff  <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_BRIGHTNESS:   csr_prdata = {27'd0, brightness_ff};
         REG_STEREO_LINK:  csr_prdata = {31'd0, stereo_link_ff};
         REG_MONITOR_MODE: csr_prdata = {30'd0, monitor_mode_ff};
         REG_LED_INHIBIT:  csr_prdata = {31'd0, led_inhibit_ff};
         default:          csr_prdata = 32'd0;
      endcase
   end

   // ------------------------------------------------------------ led levels
   // brightness of sixteen or more simply keeps the phase always below it
   assign on_phase = {1'b0, pwm_phase_ff} < brightness_ff;

   always_comb begin
      case (monitor_mode_ff)
         MON_STEADY:      mon_lit = on_phase;
         MON_LEFT_BLINK,
         MON_RIGHT_BLINK: mon_lit = on_phase && (req_data.system_time < BLINK_ON_LIMIT);
         default:         mon_lit = 1'b0;
      endcase
   end

   // ------------------------------------------------------------ end trigger loads
   // only short plays use the scaled loads, so nine bits of ms suffice
   assign long_play    = req_data.play_time_ms > LONG_PLAY_MS;
   assign ms_short     = req_data.play_time_ms[8:0];
   assign pulse_prod   = 25'(ms_short) * 25'(PULSE_RECIP);
   assign flicker_prod = 25'(ms_short) * 25'(FLICKER_RECIP);

   always_comb begin
      if (long_play) begin
         pulse_load   = LONG_PLAY_LOAD;
         flicker_load = LONG_PLAY_LOAD;
      end else begin
         pulse_load   = 6'(pulse_prod >> PULSE_SHIFT) + PULSE_OFFSET;
         flicker_load = 6'(flicker_prod >> FLICKER_SHIFT) + FLICKER_OFFSET;
      end
   end

   // ------------------------------------------------------------ per channel update
   for (genvar c = 0; c < 2; c++) begin : g_chan
      logic sel;
      assign sel = req_data.channel == 1'(c);

      // own play state, or the other channel's when stereo linked
      assign lit[c] = (play_ff[c] || (play_ff[1-c] && stereo_link_ff)) && on_phase
                      && (flicker_ff[c] == 6'd0);

      always_comb begin
         flicker_in[c] = flicker_ff[c];
         pulse_in[c]   = pulse_ff[c];
         play_in[c]    = play_ff[c];
         end_pin_in[c] = end_pin_ff[c];
         case (req_data.op)
            OP_TICK: begin
               if (flicker_ff[c] != 6'd0) begin
                  flicker_in[c] = flicker_ff[c] - 6'd1;
               end
               if (pulse_ff[c] != 6'd0) begin
                  pulse_in[c]   = pulse_ff[c] - 6'd1;
                  end_pin_in[c] = 1'b1;
               end else begin
                  end_pin_in[c] = 1'b0;
               end
            end
            OP_TRIGGER: begin
               if (sel) begin
                  play_in[c]    = 1'b0;
                  pulse_in[c]   = pulse_load;
                  flicker_in[c] = flicker_load;
                  end_pin_in[c] = 1'b1;
               end
            end
            OP_SET_STATE: begin
               if (sel) begin
                  play_in[c] = req_data.play_on;
               end
            end
            default: ;
         endcase
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            flicker_ff[c] <= 6'd0;
            pulse_ff[c]   <= 6'd0;
            play_ff[c]    <= 1'b0;
            end_pin_ff[c] <= 1'b0;
         end else if (req_fire) begin
            flicker_ff[c] <= flicker_in[c];
            pulse_ff[c]   <= pulse_in[c];
            play_ff[c]    <= play_in[c];
            end_pin_ff[c] <= end_pin_in[c];
         end
      end
   end

   // ------------------------------------------------------------ shared state
   always_comb begin
      pwm_phase_in = pwm_phase_ff;
      led_hold_in  = led_hold_ff;
      if (req_data.op == OP_TICK) begin
         // inhibit freezes the drives, the phase still advances
         if (!led_inhibit_ff) begin
            led_hold_in = {mon_lit, lit[1], lit[0]};
         end
         pwm_phase_in = pwm_phase_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_phase_ff <= 4'd0;
         led_hold_ff  <= 3'd0;
      end else if (req_fire) begin
         pwm_phase_ff <= pwm_phase_in;
         led_hold_ff  <= led_hold_in;
      end
   end

   // ------------------------------------------------------------ result register
   always_comb begin
      rsp_data_in.play_led_left  = led_hold_in[0];
      rsp_data_in.play_led_right = led_hold_in[1];
      rsp_data_in.monitor_led    = led_hold_in[2];
      rsp_data_in.end_out_left   = end_pin_in[0];
      rsp_data_in.end_out_right  = end_pin_in[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

### hdl/lpet_checker.sv
// port-level checker for the led pwm and end pulse timer, with its bind
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lpet_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input lpet_pkg::lpet_rsp_type rsp_data,
   input logic                   csr_pready
);
   import lpet_pkg::*;

   logic req_fire;
   logic rsp_stall;

   assign req_fire  = req_valid && req_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;

   // output register comes out of reset empty
   `ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)
   // every accepted transaction shows a result the next cycle
   `ASSERT_NEXT(a_fire_result, clock, reset, req_fire, rsp_valid)
   // a waiting result blocks new requests
   `ASSERT_NOW(a_stall_blocks, clock, reset, rsp_stall, !req_ready)
   // a waiting result keeps its value
   `ASSERT_NEXT(a_stall_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_data))
   // csr port never waits
   `ASSERT_NOW(a_pready, clock, reset, 1'b1, csr_pready)

endmodule

bind led_pwm_and_end_pulse_timer lpet_checker u_lpet_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_ready  (req_ready),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_data   (rsp_data),
   .csr_pready (csr_pready)
);
